/* sv/rms_pkg.sv */
// Shared types and constants of the running median smoother.
`default_nettype none

package rms_pkg;

	// Configuration register indexes and widths
	localparam int unsigned CFG_INDEX_BITS = 1;
	localparam int unsigned WS_BITS = 5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MEDIAN_ENDS = 1'b1;
	localparam logic [WS_BITS-1:0] WS_RESET = 5'd3;

	// Bit positions inside the result tuser
	localparam int unsigned USER_SERIES_DONE = 0;
	localparam int unsigned USER_TOO_SHORT = 1;
	localparam int unsigned USER_BITS = 2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_HEAD,
		ST_MED,
		ST_TAIL,
		ST_SHORT
	} state_t;

	// Commands broadcast to every cell of the row
	typedef struct packed {
		logic cmp;
		logic upd;
		logic full;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* sv/rms_cell.sv */
// One cell of the sample row: holds a sample and its rank inside the window.
`default_nettype none

module rms_cell #(
	parameter int SAMPLE_BITS = 32,
	parameter int IW = 5
) (
	input  wire                       clk,
	input  wire rms_pkg::cell_cmd_t   cmd,
	input  wire                       live,
	input  wire  [SAMPLE_BITS-1:0]    x,
	input  wire  [SAMPLE_BITS-1:0]    o,
	input  wire  [SAMPLE_BITS-1:0]    prev_value,
	input  wire  [IW-1:0]             prev_rank,
	output logic [SAMPLE_BITS-1:0]    value,
	output logic [IW-1:0]             rank,
	output logic [IW-1:0]             rank_next,
	output logic                      before_x
);

	logic [SAMPLE_BITS-1:0] value_q;
	logic [IW-1:0]          rank_q;
	logic                   xlt_s1;
	logic                   ole_s1;
	logic                   bx_s1;

	// Compare phase: order of the new sample and the leaving sample against this one
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			xlt_s1 <= $signed(x) < $signed(value_q);
			ole_s1 <= cmd.full && ($signed(o) <= $signed(value_q));
			bx_s1  <= live && ($signed(value_q) <= $signed(x));
		end
	end

	// Update phase: take the neighbor's sample with its adjusted rank
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			value_q <= prev_value;
			rank_q  <= prev_rank;
		end
	end

	// Rank after the leaving sample drops out and the new one comes in
	assign rank_next = rank_q - IW'(ole_s1) + IW'(xlt_s1);
	assign value = value_q;
	assign rank = rank_q;
	assign before_x = bx_s1;

endmodule

`default_nettype wire

/* sv/running_median_smoother.sv */
// Top level of the running median smoother: sequencer, cell row and output register.
`default_nettype none

// Centred running median over an odd window of w = window_size | 1 samples (clamped to the
// largest odd value not above WINDOW_MAX). Samples enter a row of cells in arrival order; each
// cell keeps its sample and that sample's rank in the window, so the median is the cell whose
// rank is w/2. An item is accepted, compared against every cell, and then shifts and re-ranks
// the row; the results it causes follow and leave one per cycle through the output register
// while the master side does not stall. The next item is taken while the last result still
// waits in the output register. Writing window_size drops the held samples and starts a new
// series; the end mode register may be written between any two items.
module running_median_smoother #(
	parameter int WINDOW_MAX = 31,
	parameter int SAMPLE_BITS = 32
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// sample
	input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
	input  wire                                       s_tlast,
	input  wire                                       s_tvalid,
	output logic                                      s_tready,
	// smoothed_value
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_tdata,
	output logic                                      m_tlast,
	// series_done, too_short
	output logic [rms_pkg::USER_BITS-1:0]             m_tuser,
	output logic                                      m_tvalid,
	input  wire                                       m_tready,
	input  wire                                       cfg_we,
	input  wire  [rms_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  wire  [rms_pkg::WS_BITS-1:0]               cfg_data
);

	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int TOP = (WINDOW_MAX - 1) | 1;

	rms_pkg::state_t           state_q, state_d;
	rms_pkg::cell_cmd_t        cmd;

	logic [rms_pkg::WS_BITS-1:0] ws_q;
	logic                        median_ends_q;
	logic [CW-1:0]               seen_q;
	logic [IW-1:0]               cnt_q;

	logic [SAMPLE_BITS-1:0]      x_s1;
	logic                        last_s1;
	logic                        full_s1;

	logic [CW-1:0]               w;
	logic [IW-1:0]               h;
	logic [CW-1:0]               keep;
	logic                        short_item;
	logic [SAMPLE_BITS-1:0]      o_val;
	logic [IW-1:0]               rank_x;
	logic [SAMPLE_BITS-1:0]      median;
	logic [WINDOW_MAX-1:0]       med_sel;
	logic [WINDOW_MAX-1:0]       live;
	logic [WINDOW_MAX-1:0]       before_x;

	logic [SAMPLE_BITS-1:0]      value_w [WINDOW_MAX];
	logic [IW-1:0]               rank_w [WINDOW_MAX];
	logic [IW-1:0]               rank_next_w [WINDOW_MAX];

	logic                        emit_en;
	logic                        load;
	logic [SAMPLE_BITS-1:0]      emit_value;
	logic                        emit_run_end;
	logic                        emit_done;
	logic                        emit_short;
	logic                        cnt_last;

	logic                        m_tvalid_q;
	logic [SAMPLE_BITS-1:0]      m_data_q;
	logic                        m_last_q;
	logic [rms_pkg::USER_BITS-1:0] m_user_q;

	// Effective odd window and half window
	always_comb begin
		if (int'({ws_q[rms_pkg::WS_BITS-1:1], 1'b1}) > TOP) begin
			w = CW'(TOP);
		end else begin
			w = CW'({ws_q[rms_pkg::WS_BITS-1:1], 1'b1});
		end
		h = IW'(w >> 1);
	end

	// Cells that stay in the window during this item
	assign keep = full_s1 ? (w - CW'(1)) : seen_q;
	assign short_item = !full_s1 && ((seen_q + CW'(1)) < w);
	assign o_val = value_w[IW'(w - CW'(1))];
	assign rank_x = IW'($countones(before_x));

	always_comb begin
		for (int k = 0; k < WINDOW_MAX; k++) begin
			live[k] = k < int'(keep);
		end
	end

	// Row of cells, each handing its sample and rank to the next on update
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic [SAMPLE_BITS-1:0] prev_value;
		logic [IW-1:0]          prev_rank;
		if (k == 0) begin : g_head
			assign prev_value = x_s1;
			assign prev_rank = rank_x;
		end else begin : g_link
			assign prev_value = value_w[k-1];
			assign prev_rank = rank_next_w[k-1];
		end
		rms_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.IW(IW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.live      (live[k]),
			.x         (x_s1),
			.o         (o_val),
			.prev_value(prev_value),
			.prev_rank (prev_rank),
			.value     (value_w[k]),
			.rank      (rank_w[k]),
			.rank_next (rank_next_w[k]),
			.before_x  (before_x[k])
		);
	end

	// Median: the cell inside the window whose rank is the half window
	always_comb begin
		median = '0;
		for (int k = 0; k < WINDOW_MAX; k++) begin
			med_sel[k] = (k < int'(w)) && (rank_w[k] == h);
			if (med_sel[k]) begin
				median = median | value_w[k];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rms_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = rms_pkg::ST_CMP;
				end
			end
			rms_pkg::ST_CMP: begin
				state_d = rms_pkg::ST_UPD;
			end
			rms_pkg::ST_UPD: begin
				if (short_item) begin
					state_d = last_s1 ? rms_pkg::ST_SHORT : rms_pkg::ST_IDLE;
				end else if (!full_s1 && (h != '0)) begin
					state_d = rms_pkg::ST_HEAD;
				end else begin
					state_d = rms_pkg::ST_MED;
				end
			end
			rms_pkg::ST_HEAD: begin
				if (load && cnt_last) begin
					state_d = rms_pkg::ST_MED;
				end
			end
			rms_pkg::ST_MED: begin
				if (load) begin
					state_d = (last_s1 && (h != '0)) ? rms_pkg::ST_TAIL : rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_TAIL: begin
				if (load && cnt_last) begin
					state_d = rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_SHORT: begin
				if (load) begin
					state_d = rms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rms_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs and result selection
	always_comb begin
		s_tready = 1'b0;
		cmd.cmp = 1'b0;
		cmd.upd = 1'b0;
		cmd.full = full_s1;
		emit_en = 1'b0;
		emit_value = median;
		emit_run_end = 1'b0;
		emit_done = 1'b0;
		emit_short = 1'b0;
		cnt_last = cnt_q == (h - IW'(1));
		case (state_q)
			rms_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			rms_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			rms_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
			end
			rms_pkg::ST_HEAD: begin
				emit_en = 1'b1;
				if (!median_ends_q) begin
					emit_value = value_w[IW'(w - CW'(1) - CW'(cnt_q))];
				end
			end
			rms_pkg::ST_MED: begin
				emit_en = 1'b1;
				emit_run_end = !(last_s1 && (h != '0));
				emit_done = last_s1 && (h == '0);
			end
			rms_pkg::ST_TAIL: begin
				emit_en = 1'b1;
				emit_run_end = cnt_last;
				emit_done = cnt_last;
				if (!median_ends_q) begin
					emit_value = value_w[h - IW'(1) - cnt_q];
				end
			end
			rms_pkg::ST_SHORT: begin
				emit_en = 1'b1;
				emit_value = '0;
				emit_run_end = 1'b1;
				emit_done = 1'b1;
				emit_short = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign load = emit_en && (!m_tvalid_q || m_tready);

	// Sequencer state, configuration and series fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rms_pkg::ST_IDLE;
			ws_q <= rms_pkg::WS_RESET;
			median_ends_q <= 1'b0;
			seen_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					rms_pkg::REG_WINDOW_SIZE: begin
						ws_q <= cfg_data;
						seen_q <= '0;
					end
					rms_pkg::REG_MEDIAN_ENDS: begin
						median_ends_q <= cfg_data[0];
					end
					default: begin
						median_ends_q <= median_ends_q;
					end
				endcase
			end
			if (state_q == rms_pkg::ST_UPD) begin
				if (last_s1) begin
					seen_q <= '0;
				end else if (!full_s1) begin
					seen_q <= seen_q + CW'(1);
				end
			end
			// Head and tail position counter
			if (load && ((state_q == rms_pkg::ST_HEAD) || (state_q == rms_pkg::ST_TAIL))) begin
				cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
			end
		end
	end

	// Accepted item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1 <= s_tdata[SAMPLE_BITS-1:0];
			last_s1 <= s_tlast;
			full_s1 <= seen_q >= w;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= emit_value;
			m_last_q <= emit_run_end;
			m_user_q[rms_pkg::USER_SERIES_DONE] <= emit_done;
			m_user_q[rms_pkg::USER_TOO_SHORT] <= emit_short;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = DW'(m_data_q);
	assign m_tlast = m_last_q;
	assign m_tuser = m_user_q;

	// Exactly one cell holds the median rank once the window is full
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rms_pkg::ST_MED) |-> $onehot(med_sel))
		else $error("median rank not unique in the cell row");

	// The fill count never runs past the window
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rms_pkg::ST_IDLE) |-> (seen_q <= w))
		else $error("fill count exceeds window");

	// An accepted transfer always starts the compare phase
	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == rms_pkg::ST_CMP))
		else $error("accepted item did not enter compare phase");

endmodule

`default_nettype wire
